### rtl/mdit_pkg.sv
package mdit_pkg;

  localparam int OFFSET_BITS = 16;
  localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

  localparam int MAX_RESULTS = 3;
  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_BTICK = 8'h60;

  localparam logic [3:0] KIND_BREAK  = 4'd0;
  localparam logic [3:0] KIND_BOLD   = 4'd5;
  localparam logic [3:0] KIND_ITALIC = 4'd6;
  localparam logic [3:0] KIND_CODE   = 4'd7;
  localparam logic [3:0] KIND_QUOTE  = 4'd8;
  localparam logic [3:0] KIND_PARA   = 4'd9;

  localparam logic [2:0] HASH_LEVEL_MAX = 3'd4;

  typedef enum logic [6:0] {
    M_START  = 7'b0000001,
    M_HASH   = 7'b0000010,
    M_HEAD   = 7'b0000100,
    M_EMPH   = 7'b0001000,
    M_QUOTE  = 7'b0010000,
    M_PARA   = 7'b0100000,
    M_IGNORE = 7'b1000000
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]             token_kind;
    logic [OFFSET_BITS-1:0] token_start;
    logic [OFFSET_BITS-1:0] token_length;
    logic                   run_end;
    logic                   offset_saturated;
  } out_item_t;

  function automatic logic stops_text(input logic [7:0] c);
    logic res;
    res = c inside {CH_NL, CH_HASH, CH_STAR, CH_UNDER, CH_BTICK};
    return res;
  endfunction

  function automatic logic [OFFSET_BITS-1:0] span_len(input logic [OFFSET_BITS-1:0] s,
                                                      input logic [OFFSET_BITS-1:0] e);
    logic [OFFSET_BITS-1:0] res;
    res = (e >= s) ? (e - s) : '0;
    return res;
  endfunction

endpackage

### rtl/markdown_inline_tokenizer.sv
// The tokens of an accepted byte are registered into the token queue; out_data shows its head.
// Throughput: one byte per cycle while each byte yields at most one token and out_stall is low;
//   a byte that yields two or three tokens can stall the input, as out_data carries one token.
// A four-entry token queue takes new bytes while it holds at most one token.
// Reset (synchronous, rst_n low) returns the scanner to token start at offset 0 and
//   empties the token queue.
module markdown_inline_tokenizer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mdit_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mdit_pkg::out_item_t out_data
);
  import mdit_pkg::*;

  scan_mode_t             mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] ots_r, ots_nxt;
  logic [2:0]             hc_r, hc_nxt;
  logic                   emph_r, emph_nxt;
  logic                   ovf_r, ovf_nxt;

  out_item_t              mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;

  logic                   in_acc, pop;
  logic [7:0]             c;
  logic                   last, c_zero, pos_max;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic                   proc_en, fl_en, do_disp, nx_used, ovf_step;

  scan_mode_t             mid_mode, fl_mode;
  logic [OFFSET_BITS-1:0] mid_ots, fl_ots, fl_end;
  logic [2:0]             mid_hc, fl_hc;
  logic                   mid_emph;

  out_item_t              cand [MAX_RESULTS];
  logic [MAX_RESULTS-1:0] cand_v;
  logic [1:0]             push_n;
  logic [PTR_W-1:0]       off_b, off_c;

  assign c        = in_data.text_byte;
  assign last     = in_data.final_byte;
  assign c_zero   = (c == CH_NUL);
  assign pos_max  = (pos_r == POS_MAX);
  assign pos_inc  = pos_max ? pos_r : pos_r + 1'b1;

  assign in_stall  = (cnt_r > CNT_W'(FIFO_DEPTH - MAX_RESULTS));
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  assign proc_en = (mode_r != M_IGNORE) && !c_zero;
  assign fl_en   = (mode_r != M_IGNORE) && (c_zero || last);

  always_comb begin
    mid_mode = mode_r;
    mid_ots  = ots_r;
    mid_hc   = hc_r;
    mid_emph = emph_r;
    do_disp  = 1'b0;
    nx_used  = 1'b0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      cand[i] = '{token_kind: KIND_BREAK, token_start: pos_r, token_length: '0,
                  run_end: 1'b0, offset_saturated: 1'b0};
    end
    cand_v = '0;

    if (proc_en) begin
      case (mode_r)
        M_HASH: begin
          if (c == CH_HASH) begin
            if (hc_r < HASH_LEVEL_MAX) mid_hc = hc_r + 3'd1;
          end else if (c == CH_SPACE) begin
            mid_ots  = pos_inc;
            mid_mode = M_HEAD;
            nx_used  = 1'b1;
          end else begin
            mid_ots  = pos_r;
            mid_mode = M_HEAD;
            if (stops_text(c)) begin
              cand_v[0]             = 1'b1;
              cand[0].token_kind    = {1'b0, hc_r};
              cand[0].token_start   = pos_r;
              do_disp               = 1'b1;
            end
          end
        end
        M_HEAD: begin
          if (stops_text(c)) begin
            cand_v[0]             = 1'b1;
            cand[0].token_kind    = {1'b0, hc_r};
            cand[0].token_start   = ots_r;
            cand[0].token_length  = span_len(ots_r, pos_r);
            do_disp               = 1'b1;
          end
        end
        M_EMPH: begin
          cand_v[0]           = 1'b1;
          cand[0].token_start = ots_r;
          if (c == (emph_r ? CH_UNDER : CH_STAR)) begin
            cand[0].token_kind   = KIND_BOLD;
            cand[0].token_length = OFFSET_BITS'(2);
            mid_mode             = M_START;
          end else begin
            cand[0].token_kind   = KIND_ITALIC;
            cand[0].token_length = OFFSET_BITS'(1);
            do_disp              = 1'b1;
          end
        end
        M_QUOTE: begin
          if (c == CH_NL) begin
            cand_v[0]            = 1'b1;
            cand[0].token_kind   = KIND_QUOTE;
            cand[0].token_start  = ots_r;
            cand[0].token_length = span_len(ots_r, pos_r);
            do_disp              = 1'b1;
          end
        end
        M_PARA: begin
          if (stops_text(c)) begin
            cand_v[0]            = 1'b1;
            cand[0].token_kind   = KIND_PARA;
            cand[0].token_start  = ots_r;
            cand[0].token_length = span_len(ots_r, pos_r);
            do_disp              = 1'b1;
          end
        end
        default: do_disp = 1'b1;
      endcase
    end

    if (do_disp) begin
      mid_mode             = M_START;
      cand[1].token_start  = pos_r;
      cand[1].token_length = OFFSET_BITS'(1);
      if (c == CH_NL) begin
        cand_v[1]          = 1'b1;
        cand[1].token_kind = KIND_BREAK;
      end else if (c == CH_BTICK) begin
        cand_v[1]          = 1'b1;
        cand[1].token_kind = KIND_CODE;
      end else if (c == CH_HASH) begin
        mid_mode = M_HASH;
        mid_hc   = 3'd1;
      end else if (c == CH_STAR || c == CH_UNDER) begin
        mid_mode = M_EMPH;
        mid_emph = (c == CH_UNDER);
        mid_ots  = pos_r;
      end else if (c == CH_GT) begin
        mid_mode = M_QUOTE;
        mid_ots  = pos_inc;
        nx_used  = 1'b1;
      end else begin
        mid_mode = M_PARA;
        mid_ots  = pos_r;
      end
    end

    fl_mode = c_zero ? mode_r : mid_mode;
    fl_ots  = c_zero ? ots_r  : mid_ots;
    fl_hc   = c_zero ? hc_r   : mid_hc;
    fl_end  = c_zero ? pos_r  : pos_inc;
    if (fl_en && !c_zero) nx_used = 1'b1;

    if (fl_en) begin
      case (fl_mode)
        M_HASH: begin
          cand_v[2]             = 1'b1;
          cand[2].token_kind    = {1'b0, fl_hc};
          cand[2].token_start   = fl_end;
        end
        M_HEAD: begin
          cand_v[2]             = 1'b1;
          cand[2].token_kind    = {1'b0, fl_hc};
          cand[2].token_start   = fl_ots;
          cand[2].token_length  = span_len(fl_ots, fl_end);
        end
        M_QUOTE: begin
          cand_v[2]             = 1'b1;
          cand[2].token_kind    = KIND_QUOTE;
          cand[2].token_start   = fl_ots;
          cand[2].token_length  = span_len(fl_ots, fl_end);
        end
        M_PARA: begin
          cand_v[2]             = 1'b1;
          cand[2].token_kind    = KIND_PARA;
          cand[2].token_start   = fl_ots;
          cand[2].token_length  = span_len(fl_ots, fl_end);
        end
        M_EMPH: begin
          cand_v[2]             = 1'b1;
          cand[2].token_kind    = KIND_ITALIC;
          cand[2].token_start   = fl_ots;
          cand[2].token_length  = OFFSET_BITS'(1);
        end
        default: ;
      endcase
    end

    ovf_step = ovf_r || (pos_max && nx_used);
    cand[0].run_end = !cand_v[1] && !cand_v[2];
    cand[1].run_end = !cand_v[2];
    cand[2].run_end = 1'b1;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      cand[i].offset_saturated = ovf_step;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    pos_nxt  = pos_r;
    ots_nxt  = ots_r;
    hc_nxt   = hc_r;
    emph_nxt = emph_r;
    ovf_nxt  = ovf_r;
    if (in_acc) begin
      if (last) begin
        mode_nxt = M_START;
        pos_nxt  = '0;
        ots_nxt  = '0;
        hc_nxt   = '0;
        emph_nxt = 1'b0;
        ovf_nxt  = 1'b0;
      end else if (mode_r != M_IGNORE) begin
        mode_nxt = c_zero ? M_IGNORE : mid_mode;
        ots_nxt  = mid_ots;
        hc_nxt   = mid_hc;
        emph_nxt = mid_emph;
        pos_nxt  = pos_inc;
        ovf_nxt  = ovf_step || pos_max;
      end
    end
  end

  assign push_n = in_acc ? (2'(cand_v[0]) + 2'(cand_v[1]) + 2'(cand_v[2])) : 2'd0;
  assign off_b  = PTR_W'(cand_v[0]);
  assign off_c  = PTR_W'(cand_v[0]) + PTR_W'(cand_v[1]);

  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  assign cnt_nxt    = cnt_r + CNT_W'(push_n) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (cand_v[0]) mem_r[wr_ptr_r]         <= cand[0];
      if (cand_v[1]) mem_r[wr_ptr_r + off_b] <= cand[1];
      if (cand_v[2]) mem_r[wr_ptr_r + off_c] <= cand[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_START;
      pos_r    <= '0;
      ots_r    <= '0;
      hc_r     <= '0;
      emph_r   <= 1'b0;
      ovf_r    <= 1'b0;
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      ots_r    <= ots_nxt;
      hc_r     <= hc_nxt;
      emph_r   <= emph_nxt;
      ovf_r    <= ovf_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FIFO_DEPTH))
    else $error("token queue count out of range");

  a_ignore_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && mode_r == M_IGNORE) |=> (cnt_r == $past(cnt_r) - CNT_W'($past(pop))))
    else $error("token emitted while ignoring input");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && last) |=> (pos_r == '0 && mode_r == M_START && !ovf_r))
    else $error("scanner not cleared after final byte");

  a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !last && mode_r != M_IGNORE && !pos_max) |=>
      (pos_r == $past(pos_r) + 1'b1))
    else $error("byte offset did not advance");
`endif

endmodule
